/* sv/dred_pkg.sv */
// shared types and constants of the digitizer record energy decoder
package dred_pkg;

    localparam int DEF_MAX_RAW_SAMPLES    = 1024;
    localparam int DEF_MAX_ENERGY_SAMPLES = 512;

    localparam int WORD_W = 32;
    localparam int WL_W   = 17;
    localparam int CNT_W  = 16;
    localparam int SUM_W  = 48;
    localparam int EV_W   = 49;
    localparam int ENE_W  = 33;
    localparam int DCNT_W = 6;
    localparam int TDATA_OUT_W = 128;

    localparam logic [2:0] PAT_MAXBASE = 3'd0;
    localparam logic [2:0] PAT_TRACE   = 3'd1;
    localparam logic [2:0] PAT_MEAN    = 3'd3;
    localparam logic [2:0] PAT_MEAN2   = 3'd7;

    localparam logic [7:0] REF_CHANNEL = 8'd7;

    localparam logic REG_SUBTRACT = 1'b0;
    localparam logic REG_SHIFT    = 1'b1;

    localparam logic [1:0] Q_GOOD   = 2'd0;
    localparam logic [1:0] Q_PILEUP = 2'd1;
    localparam logic [1:0] Q_NOTRIG = 2'd2;

    localparam logic [1:0] ERR_NONE    = 2'd0;
    localparam logic [1:0] ERR_RAW     = 2'd1;
    localparam logic [1:0] ERR_TRACE   = 2'd2;
    localparam logic [1:0] ERR_ZERO    = 2'd3;

    typedef enum logic [3:0] {
        PH_IDLE, PH_HEADER, PH_RAWCNT, PH_EWORD, PH_SKIP, PH_STHI, PH_STLO,
        PH_RAW, PH_ETRACE, PH_EMAX, PH_EBASE, PH_SUM, PH_TAIL, PH_TRG,
        PH_TRAILER, PH_DIV
    } phase_t;

    typedef enum logic [2:0] {
        EM_NONE, EM_REF, EM_RAWERR, EM_TRACEERR, EM_TRIG
    } emit_t;

    typedef enum logic [1:0] {
        SUM_BASE, SUM_TOP, SUM_BASE2
    } sum_part_t;

    typedef struct packed {
        logic      blk_clr;
        logic      ld_header;
        logic      ld_rawcnt;
        logic      ld_eword;
        logic      ld_sthi;
        logic      ld_stlo;
        logic      wl_dec;
        logic      wl_cnt;
        logic      wl_two;
        logic      clr_sums;
        logic      add_en;
        sum_part_t sum_sel;
        logic      ld_max;
        logic      sub_base;
        logic      div_start;
        logic      zero_energy;
        emit_t     emit;
    } cmd_t;

    typedef struct packed {
        logic       is_ref;
        logic       raw_err;
        logic       wl_zero;
        logic       wl_low;
        logic [2:0] pattern;
        logic       cnt_zero;
        logic       cnt_over;
        logic       div_done;
    } stat_t;

endpackage

/* sv/dred_ctrl.sv */
// record parsing state machine
module dred_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            acc,
    input  logic            start,
    input  logic            last,
    input  dred_pkg::stat_t st,
    output dred_pkg::cmd_t  cmd,
    output logic            busy
);

    dred_pkg::phase_t    phase_reg, phase_next;
    dred_pkg::sum_part_t sp_reg, sp_next;
    logic                dl_reg, dl_next;
    logic                sum_final;

    function automatic dred_pkg::phase_t enter_phase(input dred_pkg::stat_t s);
        dred_pkg::phase_t p;
        case (s.pattern)
            dred_pkg::PAT_MAXBASE: p = dred_pkg::PH_EMAX;
            dred_pkg::PAT_TRACE:
                p = s.cnt_over ? dred_pkg::PH_IDLE :
                    (s.cnt_zero ? dred_pkg::PH_EMAX : dred_pkg::PH_ETRACE);
            dred_pkg::PAT_MEAN, dred_pkg::PAT_MEAN2:
                p = s.cnt_zero ? dred_pkg::PH_TAIL : dred_pkg::PH_SUM;
            default: p = dred_pkg::PH_TRG;
        endcase
        return p;
    endfunction

    assign sum_final = (sp_reg == dred_pkg::SUM_TOP && st.pattern == dred_pkg::PAT_MEAN)
                    || (sp_reg == dred_pkg::SUM_BASE2);
    assign busy = (phase_reg == dred_pkg::PH_DIV);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= dred_pkg::PH_IDLE;
            sp_reg    <= dred_pkg::SUM_BASE;
            dl_reg    <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            sp_reg    <= sp_next;
            dl_reg    <= dl_next;
        end
    end

    // next state
    always_comb
    begin
        phase_next = phase_reg;
        sp_next    = sp_reg;
        dl_next    = dl_reg;
        if (acc)
        begin
            if (start)
                phase_next = last ? dred_pkg::PH_IDLE : dred_pkg::PH_HEADER;
            else
            begin
                case (phase_reg)
                    dred_pkg::PH_HEADER: phase_next = dred_pkg::PH_RAWCNT;
                    dred_pkg::PH_RAWCNT: phase_next = dred_pkg::PH_EWORD;
                    dred_pkg::PH_EWORD:  phase_next = dred_pkg::PH_SKIP;
                    dred_pkg::PH_SKIP:   phase_next = dred_pkg::PH_STHI;
                    dred_pkg::PH_STHI:   phase_next = dred_pkg::PH_STLO;
                    dred_pkg::PH_STLO:
                    begin
                        if (st.is_ref || st.raw_err)
                            phase_next = dred_pkg::PH_IDLE;
                        else if (!st.wl_zero)
                            phase_next = dred_pkg::PH_RAW;
                        else
                        begin
                            phase_next = enter_phase(st);
                            sp_next    = dred_pkg::SUM_BASE;
                        end
                    end
                    dred_pkg::PH_RAW:
                    begin
                        if (st.wl_low)
                        begin
                            phase_next = enter_phase(st);
                            sp_next    = dred_pkg::SUM_BASE;
                        end
                    end
                    dred_pkg::PH_ETRACE:
                        if (st.wl_low)
                            phase_next = dred_pkg::PH_EMAX;
                    dred_pkg::PH_EMAX:  phase_next = dred_pkg::PH_EBASE;
                    dred_pkg::PH_EBASE: phase_next = dred_pkg::PH_TRG;
                    dred_pkg::PH_SUM:
                    begin
                        if (st.wl_low)
                        begin
                            if (sum_final)
                            begin
                                phase_next = dred_pkg::PH_DIV;
                                dl_next    = last;
                            end
                            else if (sp_reg == dred_pkg::SUM_BASE)
                                sp_next = dred_pkg::SUM_TOP;
                            else
                                sp_next = dred_pkg::SUM_BASE2;
                        end
                    end
                    dred_pkg::PH_TAIL:
                        if (st.wl_low)
                            phase_next = dred_pkg::PH_TRG;
                    dred_pkg::PH_TRG:     phase_next = dred_pkg::PH_TRAILER;
                    dred_pkg::PH_TRAILER: phase_next = dred_pkg::PH_HEADER;
                    default:              phase_next = dred_pkg::PH_IDLE;
                endcase
                if (last && phase_next != dred_pkg::PH_DIV)
                    phase_next = dred_pkg::PH_IDLE;
            end
        end
        else if (phase_reg == dred_pkg::PH_DIV && st.div_done)
            phase_next = dl_reg ? dred_pkg::PH_IDLE : dred_pkg::PH_TAIL;
    end

    // commands
    always_comb
    begin
        cmd         = '0;
        cmd.sum_sel = sp_reg;
        cmd.emit    = dred_pkg::EM_NONE;
        if (acc)
        begin
            if (start)
                cmd.blk_clr = 1'b1;
            else
            begin
                case (phase_reg)
                    dred_pkg::PH_HEADER: cmd.ld_header = 1'b1;
                    dred_pkg::PH_RAWCNT: cmd.ld_rawcnt = 1'b1;
                    dred_pkg::PH_EWORD:  cmd.ld_eword  = 1'b1;
                    dred_pkg::PH_STHI:   cmd.ld_sthi   = 1'b1;
                    dred_pkg::PH_STLO, dred_pkg::PH_RAW:
                    begin
                        cmd.ld_stlo = (phase_reg == dred_pkg::PH_STLO);
                        cmd.wl_dec  = (phase_reg == dred_pkg::PH_RAW);
                        if (phase_reg == dred_pkg::PH_STLO && st.is_ref)
                            cmd.emit = dred_pkg::EM_REF;
                        else if (phase_reg == dred_pkg::PH_STLO && st.raw_err)
                            cmd.emit = dred_pkg::EM_RAWERR;
                        else if ((phase_reg == dred_pkg::PH_STLO && st.wl_zero)
                              || (phase_reg == dred_pkg::PH_RAW && st.wl_low))
                        begin
                            case (st.pattern)
                                dred_pkg::PAT_TRACE:
                                begin
                                    if (st.cnt_over)
                                        cmd.emit = dred_pkg::EM_TRACEERR;
                                    else if (!st.cnt_zero)
                                        cmd.wl_cnt = 1'b1;
                                end
                                dred_pkg::PAT_MEAN, dred_pkg::PAT_MEAN2:
                                begin
                                    cmd.clr_sums    = 1'b1;
                                    cmd.zero_energy = st.cnt_zero;
                                    cmd.wl_two      = st.cnt_zero;
                                    cmd.wl_cnt      = !st.cnt_zero;
                                end
                                default: ;
                            endcase
                        end
                    end
                    dred_pkg::PH_ETRACE: cmd.wl_dec   = 1'b1;
                    dred_pkg::PH_EMAX:   cmd.ld_max   = 1'b1;
                    dred_pkg::PH_EBASE:  cmd.sub_base = 1'b1;
                    dred_pkg::PH_SUM:
                    begin
                        cmd.add_en = 1'b1;
                        cmd.wl_dec = 1'b1;
                        if (st.wl_low)
                        begin
                            cmd.div_start = sum_final;
                            cmd.wl_cnt    = !sum_final;
                        end
                    end
                    dred_pkg::PH_TAIL: cmd.wl_dec = 1'b1;
                    dred_pkg::PH_TRG:  cmd.emit   = dred_pkg::EM_TRIG;
                    default: ;
                endcase
            end
        end
        else if (phase_reg == dred_pkg::PH_DIV && st.div_done)
            cmd.wl_two = 1'b1;
    end

endmodule

/* sv/dred_datapath.sv */
// record fields, sums, mean divider and output register
module dred_datapath #(
    parameter int MAX_RAW_SAMPLES    = dred_pkg::DEF_MAX_RAW_SAMPLES,
    parameter int MAX_ENERGY_SAMPLES = dred_pkg::DEF_MAX_ENERGY_SAMPLES
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic [dred_pkg::WORD_W-1:0]         word,
    input  dred_pkg::cmd_t                      cmd,
    output dred_pkg::stat_t                     st,
    input  logic                                cfg_we,
    input  logic                                cfg_index,
    input  logic [4:0]                          cfg_data,
    input  logic                                m_tready,
    output logic                                m_tvalid,
    output logic [dred_pkg::TDATA_OUT_W-1:0]    m_tdata,
    output logic                                m_tuser
);

    localparam int SW = dred_pkg::SUM_W;
    localparam int EW = dred_pkg::EV_W;

    logic                        sub_reg;
    logic [4:0]                  shift_reg;
    logic [dred_pkg::WL_W-1:0]   wl_reg;
    logic [7:0]                  card_reg, chan_reg, hit_reg, hit_next;
    logic [2:0]                  pat_reg;
    logic [dred_pkg::CNT_W-1:0]  cnt_reg;
    logic [31:0]                 sthi_reg, stlo_reg, ts_low;
    logic                        rawerr_reg, zero_reg;
    logic [SW-1:0]               bsum_reg, tsum_reg, b2sum_reg;
    logic signed [EW-1:0]        ev_reg;
    logic                        dpend_reg, drun_reg, dneg_reg;
    logic [dred_pkg::DCNT_W-1:0] dcnt_reg;
    logic [15:0]                 drem_reg;
    logic [SW-1:0]               dquo_reg, dq_fin;
    logic [SW:0]                 base_wide;
    logic [SW-1:0]               base, mag;
    logic [16:0]                 trial, trial_sub;
    logic                        qbit;
    logic [32:0]                 rawcnt_half;
    logic [3:0]                  ft;
    logic signed [EW-1:0]        ev_sh;
    logic                        ov_reg;
    logic [dred_pkg::TDATA_OUT_W-1:0] od_reg, od_next;
    logic                        oref_reg, oref_next;

    assign rawcnt_half = ({1'b0, word} + 33'd1) >> 1;
    assign base_wide   = ({1'b0, bsum_reg} + {1'b0, b2sum_reg}) >> 1;
    assign base        = (pat_reg == dred_pkg::PAT_MEAN2) ? base_wide[SW-1:0] : bsum_reg;
    assign mag         = (base > tsum_reg) ? base - tsum_reg : tsum_reg - base;
    assign trial       = {drem_reg, dquo_reg[SW-1]};
    assign trial_sub   = trial - {1'b0, cnt_reg};
    assign qbit        = (trial >= {1'b0, cnt_reg});
    assign dq_fin      = {dquo_reg[SW-2:0], qbit};

    assign st.is_ref   = (chan_reg == dred_pkg::REF_CHANNEL);
    assign st.raw_err  = rawerr_reg;
    assign st.wl_zero  = (wl_reg == '0);
    assign st.wl_low   = (wl_reg <= dred_pkg::WL_W'(1));
    assign st.pattern  = pat_reg;
    assign st.cnt_zero = (cnt_reg == '0);
    assign st.cnt_over = (cnt_reg > dred_pkg::CNT_W'(MAX_ENERGY_SAMPLES));
    assign st.div_done = drun_reg && (dcnt_reg == dred_pkg::DCNT_W'(1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sub_reg    <= 1'b1;
            shift_reg  <= '0;
            wl_reg     <= '0;
            card_reg   <= '0;
            chan_reg   <= '0;
            pat_reg    <= '0;
            cnt_reg    <= '0;
            sthi_reg   <= '0;
            stlo_reg   <= '0;
            rawerr_reg <= 1'b0;
            zero_reg   <= 1'b0;
            bsum_reg   <= '0;
            tsum_reg   <= '0;
            b2sum_reg  <= '0;
            ev_reg     <= '0;
            hit_reg    <= '0;
            dpend_reg  <= 1'b0;
            drun_reg   <= 1'b0;
            dcnt_reg   <= '0;
            ov_reg     <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == dred_pkg::REG_SUBTRACT)
                    sub_reg <= cfg_data[0];
                else
                    shift_reg <= cfg_data;
            end

            if (cmd.wl_two)
                wl_reg <= dred_pkg::WL_W'(2);
            else if (cmd.wl_cnt)
                wl_reg <= dred_pkg::WL_W'(cnt_reg);
            else if (cmd.ld_rawcnt)
                wl_reg <= (word > 32'(MAX_RAW_SAMPLES)) ? '0 : rawcnt_half[dred_pkg::WL_W-1:0];
            else if (cmd.wl_dec && wl_reg != '0)
                wl_reg <= wl_reg - dred_pkg::WL_W'(1);

            if (cmd.ld_header)
            begin
                card_reg <= word[31:24];
                chan_reg <= word[23:16];
            end
            if (cmd.ld_rawcnt)
                rawerr_reg <= (word > 32'(MAX_RAW_SAMPLES));
            if (cmd.ld_eword)
            begin
                pat_reg <= word[18:16];
                cnt_reg <= word[15:0];
            end
            if (cmd.ld_eword)
                zero_reg <= 1'b0;
            else if (cmd.zero_energy)
                zero_reg <= 1'b1;
            if (cmd.ld_sthi)
                sthi_reg <= word;
            if (cmd.ld_stlo)
                stlo_reg <= word;

            if (cmd.clr_sums)
            begin
                bsum_reg  <= '0;
                tsum_reg  <= '0;
                b2sum_reg <= '0;
            end
            else if (cmd.add_en)
            begin
                case (cmd.sum_sel)
                    dred_pkg::SUM_BASE: bsum_reg  <= bsum_reg  + SW'(word);
                    dred_pkg::SUM_TOP:  tsum_reg  <= tsum_reg  + SW'(word);
                    default:            b2sum_reg <= b2sum_reg + SW'(word);
                endcase
            end

            if (cmd.blk_clr || cmd.zero_energy)
                ev_reg <= '0;
            else if (cmd.ld_max)
                ev_reg <= EW'(word);
            else if (cmd.sub_base && sub_reg)
                ev_reg <= ev_reg - EW'(word);
            else if (st.div_done)
                ev_reg <= dneg_reg ? -$signed({1'b0, dq_fin}) : $signed({1'b0, dq_fin});

            if (cmd.blk_clr)
                hit_reg <= '0;
            else
                hit_reg <= hit_next;

            dpend_reg <= cmd.div_start;
            if (dpend_reg)
            begin
                drun_reg <= 1'b1;
                dcnt_reg <= dred_pkg::DCNT_W'(SW);
            end
            else if (drun_reg)
            begin
                dcnt_reg <= dcnt_reg - dred_pkg::DCNT_W'(1);
                if (dcnt_reg == dred_pkg::DCNT_W'(1))
                    drun_reg <= 1'b0;
            end

            if (cmd.emit != dred_pkg::EM_NONE)
                ov_reg <= 1'b1;
            else if (m_tready)
                ov_reg <= 1'b0;
        end
    end

    // divider datapath and output data register
    always_ff @(posedge clk)
    begin
        if (dpend_reg)
        begin
            dneg_reg <= (base > tsum_reg);
            dquo_reg <= mag;
            drem_reg <= '0;
        end
        else if (drun_reg)
        begin
            drem_reg <= qbit ? trial_sub[15:0] : trial[15:0];
            dquo_reg <= dq_fin;
        end
        if (cmd.emit != dred_pkg::EM_NONE)
        begin
            od_reg   <= od_next;
            oref_reg <= oref_next;
        end
    end

    assign ft     = word[27:24];
    assign ev_sh  = ev_reg >>> shift_reg;
    assign ts_low = cmd.ld_stlo ? word : stlo_reg;

    always_comb
    begin
        hit_next = hit_reg;
        if (cmd.emit == dred_pkg::EM_TRIG && ft != 4'd0 && hit_reg != 8'hFF)
            hit_next = hit_reg + 8'd1;
    end

    always_comb
    begin
        od_next          = '0;
        oref_next        = 1'b0;
        od_next[7:0]     = chan_reg;
        od_next[15:8]    = card_reg;
        od_next[79:16]   = {sthi_reg, ts_low};
        od_next[123:116] = hit_next;
        case (cmd.emit)
            dred_pkg::EM_REF:      oref_next = 1'b1;
            dred_pkg::EM_RAWERR:   od_next[125:124] = dred_pkg::ERR_RAW;
            dred_pkg::EM_TRACEERR: od_next[125:124] = dred_pkg::ERR_TRACE;
            dred_pkg::EM_TRIG:
            begin
                od_next[125:124] = zero_reg ? dred_pkg::ERR_ZERO : dred_pkg::ERR_NONE;
                if (ft == 4'd0)
                    od_next[115:114] = dred_pkg::Q_NOTRIG;
                else
                begin
                    od_next[112:80]  = ev_sh[dred_pkg::ENE_W-1:0];
                    od_next[113]     = 1'b1;
                    od_next[115:114] = (ft == 4'd1) ? dred_pkg::Q_GOOD : dred_pkg::Q_PILEUP;
                end
            end
            default: ;
        endcase
    end

    assign m_tvalid = ov_reg;
    assign m_tdata  = od_reg;
    assign m_tuser  = oref_reg;

endmodule

/* sv/digitizer_record_energy_decoder.sv */
// top level of the digitizer record energy decoder
//
//  channel  direction  contents
//  s_       in         tdata: data_word[31:0]; tuser: block_start; tlast: block_last
//  m_       out        tdata: channel..error_code; tuser: is_reference
//  cfg_     in         index 0 subtract_baseline, index 1 energy_shift
//
//  one word per cycle while parsing; the word that ends the mean sums of
//  patterns 3 and 7 is followed by s_tready low while the shared restoring
//  divider produces one quotient bit per cycle
//  rst_n idles the parser and resets all but the divider and output data registers
//  a word is taken while the output register is empty or being emptied
module digitizer_record_energy_decoder #(
    parameter int MAX_RAW_SAMPLES    = dred_pkg::DEF_MAX_RAW_SAMPLES,
    parameter int MAX_ENERGY_SAMPLES = dred_pkg::DEF_MAX_ENERGY_SAMPLES
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [31:0]  s_tdata,   // data_word
    input  logic         s_tuser,   // block_start
    input  logic         s_tlast,   // block_last
    output logic         m_tvalid,
    input  logic         m_tready,
    // channel, card, timestamp, energy, energy_valid, quality, gamma_count,
    // error_code, zero pad
    output logic [127:0] m_tdata,
    output logic         m_tuser,   // is_reference
    input  logic         cfg_we,
    input  logic         cfg_index,
    input  logic [4:0]   cfg_data
);

    dred_pkg::cmd_t  cmd;
    dred_pkg::stat_t st;
    logic            busy, acc;

    assign s_tready = !busy && (!m_tvalid || m_tready);
    assign acc      = s_tvalid && s_tready;

    dred_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .acc   (acc),
        .start (s_tuser),
        .last  (s_tlast),
        .st    (st),
        .cmd   (cmd),
        .busy  (busy)
    );

    dred_datapath #(
        .MAX_RAW_SAMPLES    (MAX_RAW_SAMPLES),
        .MAX_ENERGY_SAMPLES (MAX_ENERGY_SAMPLES)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .word      (s_tdata),
        .cmd       (cmd),
        .st        (st),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .m_tready  (m_tready),
        .m_tvalid  (m_tvalid),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

`ifndef ASSERT_OFF
    a_busy_stall: assert property (@(posedge clk) disable iff (!rst_n)
        busy |-> !s_tready) else $error("word taken during division");
    a_ref_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser) |->
            (m_tdata[113] == 1'b0 && m_tdata[125:124] == dred_pkg::ERR_NONE))
        else $error("reference record carries energy or error");
    a_novalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tdata[113]) |-> (m_tdata[112:80] == '0))
        else $error("energy without energy_valid");
    a_notrig: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tdata[115:114] == dred_pkg::Q_NOTRIG) |-> !m_tdata[113])
        else $error("no trigger but energy valid");
`endif

endmodule

/* bench/tb_top.sv */
// self-checking bench for the digitizer record energy decoder
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic [31:0] w;
        logic        start;
        logic        last;
    } word_t;

    typedef struct {
        logic [7:0]  channel;
        logic [7:0]  card;
        logic [63:0] stamp;
        logic [32:0] energy;
        logic        valid;
        logic [1:0]  quality;
        logic        isref;
        logic [7:0]  gammas;
        logic [1:0]  err;
    } hit_rec_t;

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [31:0]  s_tdata = '0;
    logic         s_tuser = 1'b0;
    logic         s_tlast = 1'b0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [127:0] m_tdata;
    logic         m_tuser;
    logic         cfg_we = 1'b0;
    logic         cfg_index = dred_pkg::REG_SUBTRACT;
    logic [4:0]   cfg_data = '0;

    word_t    pending[$];
    word_t    blk[$];
    hit_rec_t hits_due[$];
    int       failed = 0;
    int       hold_asks = 0;

    // decoder shadow state
    dred_pkg::phase_t p_phase;
    int unsigned p_left;
    logic [7:0]  p_card, p_chan, p_hits;
    logic [2:0]  p_pat;
    logic [15:0] p_cnt;
    logic [31:0] p_hi, p_lo;
    logic [47:0] p_base, p_top, p_base2;
    longint      p_energy;
    int          p_part;
    bit          p_rawerr, p_zero;
    bit          sub_base_cfg;
    logic [4:0]  shift_cfg;

    digitizer_record_energy_decoder uut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .s_tuser(s_tuser), .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always #5 clk = ~clk;

    task automatic queue_hit(logic [32:0] e, logic v, logic [1:0] q, logic r, logic [1:0] err);
        hit_rec_t h;
        h.channel = p_chan;
        h.card    = p_card;
        h.stamp   = {p_hi, p_lo};
        h.energy  = e;
        h.valid   = v;
        h.quality = q;
        h.isref   = r;
        h.gammas  = p_hits;
        h.err     = err;
        hits_due.push_back(h);
    endtask

    function automatic bit enter_energy();
        case (p_pat)
            dred_pkg::PAT_MAXBASE: p_phase = dred_pkg::PH_EMAX;
            dred_pkg::PAT_TRACE:
            begin
                if (p_cnt > dred_pkg::DEF_MAX_ENERGY_SAMPLES)
                begin
                    p_phase = dred_pkg::PH_IDLE;
                    return 1'b1;
                end
                if (p_cnt != 0)
                begin
                    p_left  = p_cnt;
                    p_phase = dred_pkg::PH_ETRACE;
                end
                else
                    p_phase = dred_pkg::PH_EMAX;
            end
            dred_pkg::PAT_MEAN, dred_pkg::PAT_MEAN2:
            begin
                p_base = '0;
                p_top = '0;
                p_base2 = '0;
                p_part = 0;
                if (p_cnt == 0)
                begin
                    p_zero   = 1'b1;
                    p_energy = 0;
                    p_left   = 2;
                    p_phase  = dred_pkg::PH_TAIL;
                end
                else
                begin
                    p_left  = p_cnt;
                    p_phase = dred_pkg::PH_SUM;
                end
            end
            default: p_phase = dred_pkg::PH_TRG;
        endcase
        return 1'b0;
    endfunction

    task automatic decode_word(logic [31:0] w, logic start, logic last);
        logic [48:0] b, t, mag;
        logic [3:0]  ft;
        longint      s;
        if (start)
        begin
            p_energy = 0;
            p_hits = '0;
            p_phase = last ? dred_pkg::PH_IDLE : dred_pkg::PH_HEADER;
            return;
        end
        case (p_phase)
            dred_pkg::PH_HEADER:
            begin
                p_card  = w[31:24];
                p_chan  = w[23:16];
                p_phase = dred_pkg::PH_RAWCNT;
            end
            dred_pkg::PH_RAWCNT:
            begin
                p_rawerr = w > dred_pkg::DEF_MAX_RAW_SAMPLES;
                p_left   = p_rawerr ? 0 : (w + 1) >> 1;
                p_phase  = dred_pkg::PH_EWORD;
            end
            dred_pkg::PH_EWORD:
            begin
                p_pat   = w[18:16];
                p_cnt   = w[15:0];
                p_zero  = 1'b0;
                p_phase = dred_pkg::PH_SKIP;
            end
            dred_pkg::PH_SKIP: p_phase = dred_pkg::PH_STHI;
            dred_pkg::PH_STHI:
            begin
                p_hi    = w;
                p_phase = dred_pkg::PH_STLO;
            end
            dred_pkg::PH_STLO:
            begin
                p_lo = w;
                if (p_chan == dred_pkg::REF_CHANNEL)
                begin
                    queue_hit('0, 1'b0, dred_pkg::Q_GOOD, 1'b1, dred_pkg::ERR_NONE);
                    p_phase = dred_pkg::PH_IDLE;
                end
                else if (p_rawerr)
                begin
                    queue_hit('0, 1'b0, dred_pkg::Q_GOOD, 1'b0, dred_pkg::ERR_RAW);
                    p_phase = dred_pkg::PH_IDLE;
                end
                else if (p_left != 0)
                    p_phase = dred_pkg::PH_RAW;
                else if (enter_energy())
                    queue_hit('0, 1'b0, dred_pkg::Q_GOOD, 1'b0, dred_pkg::ERR_TRACE);
            end
            dred_pkg::PH_RAW:
            begin
                if (p_left > 0)
                    p_left--;
                if (p_left == 0 && enter_energy())
                    queue_hit('0, 1'b0, dred_pkg::Q_GOOD, 1'b0, dred_pkg::ERR_TRACE);
            end
            dred_pkg::PH_ETRACE:
            begin
                if (p_left > 0)
                    p_left--;
                if (p_left == 0)
                    p_phase = dred_pkg::PH_EMAX;
            end
            dred_pkg::PH_EMAX:
            begin
                p_energy = longint'({32'b0, w});
                p_phase  = dred_pkg::PH_EBASE;
            end
            dred_pkg::PH_EBASE:
            begin
                if (sub_base_cfg)
                    p_energy = p_energy - longint'({32'b0, w});
                p_phase = dred_pkg::PH_TRG;
            end
            dred_pkg::PH_SUM:
            begin
                case (p_part)
                    0: p_base = p_base + w;
                    1: p_top = p_top + w;
                    default: p_base2 = p_base2 + w;
                endcase
                if (p_left > 0)
                    p_left--;
                if (p_left == 0)
                begin
                    p_part++;
                    if ((p_part == 2 && p_pat == dred_pkg::PAT_MEAN) || p_part >= 3)
                    begin
                        b = {1'b0, p_base};
                        t = {1'b0, p_top};
                        if (p_pat == dred_pkg::PAT_MEAN2)
                            b = ({1'b0, p_base} + {1'b0, p_base2}) >> 1;
                        mag = (b > t) ? b - t : t - b;
                        mag = mag / {33'b0, p_cnt};
                        p_energy = (b > t) ? -longint'(mag) : longint'(mag);
                        p_left = 2;
                        p_phase = dred_pkg::PH_TAIL;
                    end
                    else
                        p_left = p_cnt;
                end
            end
            dred_pkg::PH_TAIL:
            begin
                if (p_left > 0)
                    p_left--;
                if (p_left == 0)
                    p_phase = dred_pkg::PH_TRG;
            end
            dred_pkg::PH_TRG:
            begin
                ft = w[27:24];
                if (ft == 0)
                    queue_hit('0, 1'b0, dred_pkg::Q_NOTRIG, 1'b0,
                              p_zero ? dred_pkg::ERR_ZERO : dred_pkg::ERR_NONE);
                else
                begin
                    s = p_energy >>> shift_cfg;
                    if (p_hits < 8'd255)
                        p_hits++;
                    queue_hit(s[32:0], 1'b1,
                              (ft == 1) ? dred_pkg::Q_GOOD : dred_pkg::Q_PILEUP, 1'b0,
                              p_zero ? dred_pkg::ERR_ZERO : dred_pkg::ERR_NONE);
                end
                p_phase = dred_pkg::PH_TRAILER;
            end
            dred_pkg::PH_TRAILER: p_phase = dred_pkg::PH_HEADER;
            default: p_phase = dred_pkg::PH_IDLE;
        endcase
        if (last)
            p_phase = dred_pkg::PH_IDLE;
    endtask

    // word driver
    int  tx_gap = 0;
    bit  tx_calm = 1'b0;
    always @(posedge clk or negedge rst_n)
    begin
        word_t nw;
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
        end
        else
        begin
            if (s_tvalid && s_tready)
                decode_word(s_tdata, s_tuser, s_tlast);
            if ($urandom_range(0, 149) == 0)
                tx_calm = ~tx_calm;
            if (!s_tvalid || s_tready)
            begin
                if (tx_gap > 0)
                begin
                    tx_gap--;
                    s_tvalid <= 1'b0;
                end
                else if (pending.size() > 0)
                begin
                    nw = pending.pop_front();
                    s_tdata  <= nw.w;
                    s_tuser  <= nw.start;
                    s_tlast  <= nw.last;
                    s_tvalid <= 1'b1;
                    tx_gap = tx_calm ? 0 : $urandom_range(0, 13);
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // result monitor
    int  rx_stall = 0;
    int  rx_hold = 0;
    int  holds_seen = 0;
    bit  rx_calm = 1'b0;
    always @(posedge clk or negedge rst_n)
    begin
        hit_rec_t h;
        if (!rst_n)
        begin
            m_tready <= 1'b0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (hits_due.size() == 0)
                begin
                    $error("unexpected result word %h", m_tdata);
                    failed++;
                end
                else
                begin
                    h = hits_due.pop_front();
                    if (m_tdata[7:0] !== h.channel)
                    begin
                        $error("channel exp %h got %h", h.channel, m_tdata[7:0]);
                        failed++;
                    end
                    if (m_tdata[15:8] !== h.card)
                    begin
                        $error("card exp %h got %h", h.card, m_tdata[15:8]);
                        failed++;
                    end
                    if (m_tdata[79:16] !== h.stamp)
                    begin
                        $error("timestamp exp %h got %h", h.stamp, m_tdata[79:16]);
                        failed++;
                    end
                    if (m_tdata[112:80] !== h.energy)
                    begin
                        $error("energy exp %h got %h", h.energy, m_tdata[112:80]);
                        failed++;
                    end
                    if (m_tdata[113] !== h.valid)
                    begin
                        $error("energy_valid exp %b got %b", h.valid, m_tdata[113]);
                        failed++;
                    end
                    if (m_tdata[115:114] !== h.quality)
                    begin
                        $error("quality exp %0d got %0d", h.quality, m_tdata[115:114]);
                        failed++;
                    end
                    if (m_tdata[123:116] !== h.gammas)
                    begin
                        $error("gamma_count exp %0d got %0d", h.gammas, m_tdata[123:116]);
                        failed++;
                    end
                    if (m_tdata[125:124] !== h.err)
                    begin
                        $error("error_code exp %0d got %0d", h.err, m_tdata[125:124]);
                        failed++;
                    end
                    if (m_tuser !== h.isref)
                    begin
                        $error("is_reference exp %b got %b", h.isref, m_tuser);
                        failed++;
                    end
                end
            end
            if ($urandom_range(0, 149) == 0)
                rx_calm = ~rx_calm;
            if (holds_seen != hold_asks)
            begin
                holds_seen = hold_asks;
                rx_hold = 600;
            end
            if (rx_hold > 0)
            begin
                rx_hold--;
                m_tready <= 1'b0;
            end
            else if (rx_stall > 0)
            begin
                rx_stall--;
                m_tready <= 1'b0;
            end
            else
            begin
                m_tready <= 1'b1;
                if (m_tvalid && m_tready)
                    rx_stall = rx_calm ? 0 : $urandom_range(0, 13);
            end
        end
    end

    task automatic add(logic [31:0] w);
        word_t x;
        x.w = w;
        x.start = 1'b0;
        x.last = 1'b0;
        blk.push_back(x);
    endtask

    task automatic gen_record(bit is_ref);
        logic [7:0]  chan;
        logic [31:0] rawcnt;
        logic [2:0]  pat;
        logic [15:0] cnt;
        logic [3:0]  ft;
        int          r, nwords;
        chan = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 6));
        if (is_ref)
            chan = dred_pkg::REF_CHANNEL;
        else if (chan == dred_pkg::REF_CHANNEL)
            chan = 8'd8;
        add({8'($urandom), chan, 16'($urandom)});
        r = $urandom_range(0, 19);
        if (r == 0)
        begin
            rawcnt = $urandom;
            if (rawcnt <= dred_pkg::DEF_MAX_RAW_SAMPLES)
                rawcnt = dred_pkg::DEF_MAX_RAW_SAMPLES + 1;
        end
        else
            rawcnt = $urandom_range(0, 5);
        add(rawcnt);
        r = $urandom_range(0, 9);
        case (r)
            0, 1: pat = dred_pkg::PAT_MAXBASE;
            2, 3: pat = dred_pkg::PAT_TRACE;
            4, 5: pat = dred_pkg::PAT_MEAN;
            6, 7: pat = dred_pkg::PAT_MEAN2;
            default:
            begin
                r = $urandom_range(0, 3);
                pat = (r == 0) ? 3'd2 : 3'd4 + 3'(r - 1);
            end
        endcase
        if (pat == dred_pkg::PAT_MEAN || pat == dred_pkg::PAT_MEAN2)
            cnt = $urandom_range(0, 4);
        else if (pat == dred_pkg::PAT_TRACE)
            cnt = ($urandom_range(0, 7) == 0) ? 16'($urandom_range(513, 65535))
                                              : 16'($urandom_range(0, 4));
        else
            cnt = 16'($urandom);
        add({13'($urandom), pat, cnt});
        repeat (3) add($urandom);
        if (is_ref || rawcnt > dred_pkg::DEF_MAX_RAW_SAMPLES)
            return;
        repeat ((rawcnt + 1) / 2) add($urandom);
        if (pat == dred_pkg::PAT_TRACE && cnt > dred_pkg::DEF_MAX_ENERGY_SAMPLES)
            return;
        case (pat)
            dred_pkg::PAT_MAXBASE: nwords = 2;
            dred_pkg::PAT_TRACE: nwords = cnt + 2;
            dred_pkg::PAT_MEAN: nwords = 2 * cnt + 2;
            dred_pkg::PAT_MEAN2: nwords = 3 * cnt + 2;
            default: nwords = 0;
        endcase
        repeat (nwords) add($urandom);
        r = $urandom_range(0, 2);
        ft = (r == 0) ? 4'd0 : (r == 1) ? 4'd1 : 4'($urandom_range(2, 15));
        add({4'($urandom), ft, 24'($urandom)});
        add($urandom);
    endtask

    task automatic ship_block(bit cut);
        int keep;
        if (cut)
        begin
            keep = $urandom_range(1, blk.size());
            while (blk.size() > keep)
                void'(blk.pop_back());
        end
        blk[blk.size() - 1].last = 1'b1;
        foreach (blk[i])
            pending.push_back(blk[i]);
        blk.delete();
    endtask

    task automatic gen_block();
        word_t x;
        int    n;
        repeat ($urandom_range(0, 3) == 0 ? $urandom_range(1, 3) : 0)
        begin
            x.w = $urandom;
            x.start = $urandom_range(0, 1);
            x.last = $urandom_range(0, 1);
            pending.push_back(x);
        end
        x.w = $urandom;
        x.start = 1'b1;
        x.last = 1'b0;
        blk.push_back(x);
        n = $urandom_range(0, 6);
        repeat (n) gen_record(1'b0);
        if ($urandom_range(0, 1) == 1)
            gen_record(1'b1);
        ship_block($urandom_range(0, 7) == 0);
    endtask

    task automatic wait_drained();
        while (pending.size() != 0 || s_tvalid || hits_due.size() != 0)
            @(negedge clk);
        repeat (100) @(negedge clk);
    endtask

    task automatic set_regs(bit sub, logic [4:0] sh);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= dred_pkg::REG_SUBTRACT;
        cfg_data <= {4'b0, sub};
        @(posedge clk);
        cfg_index <= dred_pkg::REG_SHIFT;
        cfg_data <= sh;
        @(posedge clk);
        cfg_we <= 1'b0;
        sub_base_cfg = sub;
        shift_cfg = sh;
        @(negedge clk);
    endtask

    task automatic run_phase(bit sub, logic [4:0] sh, int nwords, bit long_hold);
        int base;
        set_regs(sub, sh);
        base = pending.size();
        if (long_hold)
            hold_asks++;
        for (int made = 0; made < nwords; made = made + 0)
        begin
            base = pending.size();
            gen_block();
            made += pending.size() - base;
            @(negedge clk);
        end
        wait_drained();
    endtask

    initial
    begin
        word_t x;
        p_phase = dred_pkg::PH_IDLE;
        p_left = 0;
        {p_card, p_chan, p_hits, p_pat, p_cnt, p_hi, p_lo} = '0;
        {p_base, p_top, p_base2} = '0;
        p_energy = 0;
        p_part = 0;
        p_rawerr = 0;
        p_zero = 0;
        sub_base_cfg = 1'b1;
        shift_cfg = '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        set_regs(1'b1, 5'd0);

        // directed block: extreme energies, zero sample count, raw overflow
        x.w = '1;
        x.start = 1'b1;
        x.last = 1'b0;
        blk.push_back(x);
        add(32'hFF00_0000);
        add(32'd0);
        add({13'd0, dred_pkg::PAT_MAXBASE, 16'd0});
        add(32'd0);
        add(32'hFFFF_FFFF);
        add(32'd0);
        add(32'hFFFF_FFFF);
        add(32'd0);
        add(32'h0100_0000);
        add(32'd0);
        add(32'h00FF_FFFF);
        add(32'd1);
        add({13'h1FFF, dred_pkg::PAT_MEAN, 16'd0});
        add('1);
        add(32'd0);
        add('1);
        add('1);
        add(32'd0);
        add('1);
        add(32'hF0FF_FFFF);
        add('1);
        add(32'h0102_0000);
        add(32'd1025);
        ship_block(1'b0);
        wait_drained();

        run_phase(1'b1, 5'd0, 180, 1'b0);
        run_phase(1'b0, 5'd31, 180, 1'b0);
        run_phase(1'b1, 5'd31, 180, 1'b1);
        run_phase(1'b0, 5'd0, 180, 1'b0);
        run_phase(1'b1, 5'($urandom_range(1, 30)), 180, 1'b0);

        if (failed == 0 && hits_due.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
